// ----- rtl/core/ace_pkg.sv -----
// ----------------------------------------------------------------------------
// ace_pkg: shared types and constants
// Transaction payloads, decoded micro-op and machine codes for the
// accumulator machine execute block.
// ----------------------------------------------------------------------------
package ace_pkg;

   localparam int PC_BITS     = 16;
   localparam int DATA_DEPTH  = 256;
   localparam int ADDR_BITS   = $clog2(DATA_DEPTH);
   localparam int DATA_BITS   = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      OP_NOOP    = 4'd0,
      OP_ALU_IMM = 4'd1,
      OP_ALU_MEM = 4'd2,
      OP_CLEAR   = 4'd3,
      OP_STORE   = 4'd4,
      OP_BEQZ    = 4'd5,
      OP_HALT    = 4'd15
   } opcode_type;

   typedef enum logic [3:0] {
      SEL_ADD = 4'd0,
      SEL_SUB = 4'd1
   } alu_sel_type;

   typedef enum logic [2:0] {
      CLS_NOOP,
      CLS_ALU_IMM,
      CLS_ALU_MEM,
      CLS_CLEAR,
      CLS_STORE,
      CLS_BEQZ,
      CLS_HALT,
      CLS_INVALID
   } cls_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_NONE
   } alu_type;

   typedef enum logic [1:0] {
      ST_RUN     = 2'd0,
      ST_HALTED  = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

   typedef struct packed {
      logic [3:0] opcode;
      logic [3:0] alu_select;
      logic [7:0] operand;
   } req_type;

   typedef struct packed {
      logic [15:0]       next_pc;
      logic signed [7:0] accumulator_value;
      logic              zero_flag;
      logic              carry_flag;
      logic              overflow_flag;
      logic [1:0]        run_status;
   } rsp_type;

   typedef struct packed {
      cls_type    cls;
      alu_type    alu;
      logic [7:0] operand;
   } uop_type;

endpackage

// ----- rtl/core/ace_ram.sv -----
// ----------------------------------------------------------------------------
// ace_ram: generic single-port-write RAM
// One write port, one read port, registered read data (read-old on collision).
// ----------------------------------------------------------------------------
module ace_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/ace_front.sv -----
// ----------------------------------------------------------------------------
// ace_front: instruction intake
// Accepts request transactions, decodes them into micro-ops and buffers
// them in a short queue toward the execute side.
// ----------------------------------------------------------------------------
module ace_front import ace_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    uop_valid,
   output uop_type uop_data,
   input  logic    uop_pop
);

   uop_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;
   uop_type               dec;
   logic                  push;
   logic                  pop;

   // decode
   always_comb begin
      dec.operand = req_data.operand;
      unique case (req_data.alu_select)
         SEL_ADD: dec.alu = ALU_ADD;
         SEL_SUB: dec.alu = ALU_SUB;
         default: dec.alu = ALU_NONE;
      endcase
      unique case (req_data.opcode)
         OP_NOOP:    dec.cls = CLS_NOOP;
         OP_ALU_IMM: dec.cls = CLS_ALU_IMM;
         OP_ALU_MEM: dec.cls = CLS_ALU_MEM;
         OP_CLEAR:   dec.cls = CLS_CLEAR;
         OP_STORE:   dec.cls = CLS_STORE;
         OP_BEQZ:    dec.cls = CLS_BEQZ;
         OP_HALT:    dec.cls = CLS_HALT;
         default:    dec.cls = CLS_INVALID;
      endcase
   end

   assign req_ready = (count_ff < QCNT_BITS'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign uop_valid = (count_ff != '0);
   assign pop       = uop_pop && uop_valid;
   assign uop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= dec;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("queue count exceeds depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");
`endif

endmodule

// ----- rtl/core/ace_back.sv -----
// ----------------------------------------------------------------------------
// ace_back: execute side
// Issues the data memory read, then executes the micro-op against the
// architectural state and presents the result transaction.
// ----------------------------------------------------------------------------
module ace_back import ace_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    uop_valid,
   input  uop_type uop_data,
   output logic    uop_pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic [PC_BITS-1:0]   pc_ff, pc_in;
   logic [DATA_BITS-1:0] acc_ff, acc_in;
   logic                 zf_ff, zf_in;
   logic                 cf_ff, cf_in;
   logic                 vf_ff, vf_in;
   status_type           status_ff, status_in;
   uop_type              ex_ff;
   logic                 ex_valid_ff;
   logic                 fwd_ff, fwd_in;
   logic                 vld_rd_ff;
   logic [DATA_DEPTH-1:0] vld_ff;
   logic                 rsp_valid_ff;

   logic                 rd_fire;
   logic                 ex_fire;
   logic                 mem_wr_en;
   logic [DATA_BITS-1:0] mem_rd_data;
   logic [DATA_BITS-1:0] mem_byte;
   logic [DATA_BITS-1:0] alu_b;
   logic [DATA_BITS:0]   sum9;
   logic [DATA_BITS:0]   dif9;

   assign ex_fire = ex_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign rd_fire = uop_valid && (!ex_valid_ff || ex_fire);
   assign uop_pop = rd_fire;

   assign mem_wr_en = ex_fire && (status_ff == ST_RUN) && (ex_ff.cls == CLS_STORE);
   // store in execute hits the address being read: its data is the live acc
   assign fwd_in = mem_wr_en && (uop_data.operand[ADDR_BITS-1:0] ==
                                 ex_ff.operand[ADDR_BITS-1:0]);

   ace_ram #(
      .WIDTH (DATA_BITS),
      .DEPTH (DATA_DEPTH)
   ) u_dmem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (ex_ff.operand[ADDR_BITS-1:0]),
      .wr_data (acc_ff),
      .rd_en   (rd_fire),
      .rd_addr (uop_data.operand[ADDR_BITS-1:0]),
      .rd_data (mem_rd_data)
   );

   // never-written bytes read as zero
   assign mem_byte = fwd_ff ? acc_ff : (vld_rd_ff ? mem_rd_data : '0);
   assign alu_b    = (ex_ff.cls == CLS_ALU_IMM) ? ex_ff.operand : mem_byte;
   assign sum9     = {1'b0, acc_ff} + {1'b0, alu_b};
   assign dif9     = {1'b0, acc_ff} - {1'b0, alu_b};

   always_comb begin
      pc_in     = pc_ff;
      acc_in    = acc_ff;
      zf_in     = zf_ff;
      cf_in     = cf_ff;
      vf_in     = vf_ff;
      status_in = status_ff;
      if (status_ff == ST_RUN) begin
         pc_in = pc_ff + 1'b1;
         case (ex_ff.cls) inside
            CLS_ALU_IMM, CLS_ALU_MEM: begin
               if (ex_ff.alu == ALU_ADD) begin
                  acc_in = sum9[DATA_BITS-1:0];
                  cf_in  = sum9[DATA_BITS];
                  vf_in  = (acc_ff[7] == alu_b[7]) && (sum9[7] != acc_ff[7]);
                  zf_in  = (sum9[DATA_BITS-1:0] == '0);
               end else if (ex_ff.alu == ALU_SUB) begin
                  acc_in = dif9[DATA_BITS-1:0];
                  cf_in  = dif9[DATA_BITS];
                  vf_in  = (acc_ff[7] != alu_b[7]) && (dif9[7] != acc_ff[7]);
                  zf_in  = (dif9[DATA_BITS-1:0] == '0);
               end
            end
            CLS_CLEAR: begin
               acc_in = '0;
               zf_in  = 1'b1;
               cf_in  = 1'b0;
               vf_in  = 1'b0;
            end
            CLS_BEQZ: begin
               if (acc_ff == '0) begin
                  pc_in = PC_BITS'(ex_ff.operand);
               end
            end
            CLS_HALT:    status_in = ST_HALTED;
            CLS_INVALID: status_in = ST_INVALID;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         acc_ff       <= '0;
         zf_ff        <= 1'b0;
         cf_ff        <= 1'b0;
         vf_ff        <= 1'b0;
         status_ff    <= ST_RUN;
         ex_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
      end else begin
         if (ex_fire) begin
            pc_ff     <= pc_in;
            acc_ff    <= acc_in;
            zf_ff     <= zf_in;
            cf_ff     <= cf_in;
            vf_ff     <= vf_in;
            status_ff <= status_in;
         end
         if (mem_wr_en) begin
            vld_ff[ex_ff.operand[ADDR_BITS-1:0]] <= 1'b1;
         end
         if (rd_fire) begin
            ex_valid_ff <= 1'b1;
         end else if (ex_fire) begin
            ex_valid_ff <= 1'b0;
         end
         if (ex_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_fire) begin
         ex_ff     <= uop_data;
         fwd_ff    <= fwd_in;
         vld_rd_ff <= vld_ff[uop_data.operand[ADDR_BITS-1:0]];
      end
   end

   // state only moves on execute, so the registers double as the result
   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_data.next_pc           = 16'(pc_ff);
   assign rsp_data.accumulator_value = $signed(acc_ff);
   assign rsp_data.zero_flag         = zf_ff;
   assign rsp_data.carry_flag        = cf_ff;
   assign rsp_data.overflow_flag     = vf_ff;
   assign rsp_data.run_status        = status_ff;

`ifndef SYNTHESIS
   a_stop_sticks: assert property (@(posedge clock) disable iff (reset)
      (status_ff != ST_RUN) |=> (status_ff == $past(status_ff)))
      else $error("stopped machine resumed");

   a_pc_only_on_exec: assert property (@(posedge clock) disable iff (reset)
      !ex_fire |=> $stable(pc_ff))
      else $error("pc moved without an execute");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ex_fire))
      else $error("result raised without an execute");

   a_no_store_when_stopped: assert property (@(posedge clock) disable iff (reset)
      (status_ff != ST_RUN) |-> !mem_wr_en)
      else $error("memory written while stopped");
`endif

endmodule

// ----- rtl/core/accumulator_cpu_execute.sv -----
// ----------------------------------------------------------------------------
// accumulator_cpu_execute: 8-bit accumulator machine execute block
// Top level: intake/decode queue in front, memory read and execute behind.
// ----------------------------------------------------------------------------
// Each request transaction is one instruction (opcode, ALU select, operand);
// each produces exactly one response transaction carrying the machine state
// after it: next pc, accumulator, zero/carry/overflow flags and run status.
// Sustained rate is one instruction per clock while responses are taken; a
// result is registered in turn in a queue slot, at the data memory read and
// by the execute into the result registers after its request is accepted.
// The registered read port of the 256-byte data memory is read as the
// micro-op enters the execute stage, ahead of the 8-bit add/subtract there;
// a STORE directly followed by a read of the same byte is forwarded, so
// there are no bubbles. Data memory comes out of reset reading all zero via
// per-byte valid flops, so no clearing pass is needed and requests are taken
// right after reset. HALT or an invalid opcode freezes the state until reset;
// later transactions still get a response repeating that state.
// ----------------------------------------------------------------------------
module accumulator_cpu_execute import ace_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // decoded micro-op handoff between intake and execute
   logic    uop_valid;
   uop_type uop_data;
   logic    uop_pop;

   ace_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .uop_valid (uop_valid),
      .uop_data  (uop_data),
      .uop_pop   (uop_pop)
   );

   ace_back u_back (
      .clock     (clock),
      .reset     (reset),
      .uop_valid (uop_valid),
      .uop_data  (uop_data),
      .uop_pop   (uop_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
